### hw/rtl/sobel_pkg.sv
// shared constants, register codes and beat types for the sobel edge stream
package sobel_pkg;

    localparam int MAX_WIDTH_DFLT = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MIN_DIM        = 3;
    localparam int CFG_DW         = 13;
    localparam int CFG_IW         = 2;
    localparam int PIX_W          = 8;
    localparam int COORD_W        = 12;
    localparam int ROW_W          = 12;
    localparam int SUM_W          = 10;
    localparam int TDATA_W        = 32;

    localparam logic [CFG_DW-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_DW-1:0] HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IW-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // pixel beat after the line buffer read, with its window column
    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               last;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   mid;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
    } lb_beat_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [PIX_W-1:0]   edge_value;
        logic               frame_last;
    } sobel_result_t;

endpackage

### hw/rtl/sobel_edge_magnitude_stream.sv
// Sobel 3x3 edge magnitude over a raster pixel stream. One pixel beat is taken per clock,
// back to back, for as long as the output side keeps up; a result passes the line buffer stage,
// the window, sum and output registers. The rate is set by the single line buffer memory,
// which holds the two previous rows per column, is read at the column of the incoming
// pixel and written back from the line buffer stage, with forwarding when both hit the
// same column. The output has a two-entry skid stage, so s_tready depends only on
// registers. Border pixels give no result; frame_start restarts the position, otherwise
// rows and frames wrap on their own. Write frame_width and frame_height only while the block is idle.
module sobel_edge_magnitude_stream
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DFLT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,   // pixel_value
    input  logic               s_tuser,   // frame_start
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // edge_value, out_row, out_col
    output logic               m_tlast    // frame_last
);

    logic [CFG_DW-1:0] frame_width_reg;
    logic [CFG_DW-1:0] frame_height_reg;
    logic              adv;
    lb_beat_t          beat;
    logic              res_valid;
    sobel_result_t     res;

    logic              main_valid_reg;
    logic              main_valid_next;
    sobel_result_t     main_data_reg;
    sobel_result_t     main_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    sobel_result_t     skid_data_reg;
    logic              res_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // the whole pipeline moves while the skid entry is free
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign res_take = adv && res_valid;

    sobel_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .pixel_value  (s_tdata),
        .frame_start  (s_tuser),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .beat         (beat)
    );

    sobel_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = res_take;
                main_data_next  = res;
            end
        end
        else if (res_take)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        if (main_valid_reg && !m_tready && res_take)
            skid_data_reg <= res;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {main_data_reg.out_col, main_data_reg.out_row, main_data_reg.edge_value};
    assign m_tlast  = main_data_reg.frame_last;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (main_data_reg.out_row != '0))
        else $error("result emitted for a border row");

endmodule

### hw/rtl/sobel_line_buf.sv
// position counters and the two-row line buffer memory with write forwarding
module sobel_line_buf
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DFLT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [PIX_W-1:0]  pixel_value,
    input  logic              frame_start,
    input  logic [CFG_DW-1:0] frame_width,
    input  logic [CFG_DW-1:0] frame_height,
    output lb_beat_t          beat
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;
    localparam int MW   = 2 * PIX_W;

    logic [CMPW-1:0]   w_cfg;
    logic [CMPW-1:0]   w_eff;
    logic [CFG_DW-1:0] h_eff;
    logic              accept;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [ROW_W-1:0]  row_cur;
    logic [CW-1:0]     col_cur;
    logic [CMPW-1:0]   col_inc;
    logic [CFG_DW-1:0] row_inc;
    logic              col_wrap;
    logic              row_wrap;
    logic              emit0;
    logic              last0;

    logic              v1_reg;
    logic              emit1_reg;
    logic              last1_reg;
    logic [PIX_W-1:0]  px1_reg;
    logic [COORD_W-1:0] row1_reg;
    logic [COORD_W-1:0] col1o_reg;
    logic [CW-1:0]     addr1_reg;
    logic              fwd_reg;
    logic [MW-1:0]     fwd_data_reg;
    logic [MW-1:0]     rd_reg;
    logic [MW-1:0]     word1;
    logic [MW-1:0]     wr_data;

    // each word holds {row r-2, row r-1} for one column
    logic [MW-1:0]     line_mem [MAX_WIDTH];

    assign w_cfg = CMPW'(frame_width);

    always_comb
    begin
        if (w_cfg < CMPW'(MIN_DIM))
            w_eff = CMPW'(MIN_DIM);
        else if (w_cfg > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else
            w_eff = w_cfg;
        if (frame_height < CFG_DW'(MIN_DIM))
            h_eff = CFG_DW'(MIN_DIM);
        else if (frame_height > CFG_DW'(MAX_HEIGHT))
            h_eff = CFG_DW'(MAX_HEIGHT);
        else
            h_eff = frame_height;
    end

    assign accept  = adv && in_valid;
    assign row_cur = frame_start ? '0 : row_reg;
    assign col_cur = frame_start ? '0 : col_reg;
    assign col_inc = CMPW'(col_cur) + CMPW'(1);
    assign row_inc = CFG_DW'(row_cur) + CFG_DW'(1);
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= h_eff);

    always_comb
    begin
        col_next = col_wrap ? '0 : col_inc[CW-1:0];
        if (col_wrap)
            row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
        else
            row_next = row_cur;
    end

    assign emit0 = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2))
                && (CFG_DW'(row_cur) < h_eff) && (CMPW'(col_cur) < w_eff);
    assign last0 = (row_inc == h_eff) && (col_inc == w_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                fwd_reg <= v1_reg && (col_cur == addr1_reg);
            end
            if (adv)
                v1_reg <= in_valid;
        end
    end

    // newer data from the beat ahead overrides a stale read at the same column
    assign word1   = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {word1[PIX_W-1:0], px1_reg};

    always_ff @(posedge clk)
    begin
        if (adv && v1_reg)
            line_mem[addr1_reg] <= wr_data;
        if (accept)
        begin
            rd_reg       <= line_mem[col_cur];
            fwd_data_reg <= wr_data;
            emit1_reg    <= emit0;
            last1_reg    <= last0;
            px1_reg      <= pixel_value;
            row1_reg     <= COORD_W'(row_cur - ROW_W'(1));
            col1o_reg    <= COORD_W'(col_cur - CW'(1));
            addr1_reg    <= col_cur;
        end
    end

    always_comb
    begin
        beat.valid   = v1_reg;
        beat.emit    = emit1_reg;
        beat.last    = last1_reg;
        beat.px      = px1_reg;
        beat.top     = word1[MW-1:PIX_W];
        beat.mid     = word1[PIX_W-1:0];
        beat.out_row = row1_reg;
        beat.out_col = col1o_reg;
    end

endmodule

### hw/rtl/sobel_grad.sv
// 3x3 window shift register and the two-stage gradient magnitude datapath
module sobel_grad
    import sobel_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  lb_beat_t      beat,
    output logic          res_valid,
    output sobel_result_t res
);

    logic [PIX_W-1:0]   win_reg [9];
    logic               v2_reg;
    logic               last2_reg;
    logic [COORD_W-1:0] row2_reg;
    logic [COORD_W-1:0] col2_reg;

    logic [SUM_W-1:0]   up_next;
    logic [SUM_W-1:0]   dn_next;
    logic [SUM_W-1:0]   rt_next;
    logic [SUM_W-1:0]   lf_next;

    logic               v3_reg;
    logic               last3_reg;
    logic [COORD_W-1:0] row3_reg;
    logic [COORD_W-1:0] col3_reg;
    logic [SUM_W-1:0]   up_reg;
    logic [SUM_W-1:0]   dn_reg;
    logic [SUM_W-1:0]   rt_reg;
    logic [SUM_W-1:0]   lf_reg;

    logic [SUM_W-1:0]   diff_y;
    logic [SUM_W-1:0]   diff_x;
    logic [SUM_W:0]     total;

    // window index is row*3 + col, row 0 on top, col 0 on the left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (beat.valid)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]     <= win_reg[k*3 + 1];
                    win_reg[k*3 + 1] <= win_reg[k*3 + 2];
                end
                win_reg[2] <= beat.top;
                win_reg[5] <= beat.mid;
                win_reg[8] <= beat.px;
            end
            v2_reg <= beat.valid && beat.emit;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        up_next = SUM_W'(win_reg[0]) + (SUM_W'(win_reg[1]) << 1) + SUM_W'(win_reg[2]);
        dn_next = SUM_W'(win_reg[6]) + (SUM_W'(win_reg[7]) << 1) + SUM_W'(win_reg[8]);
        rt_next = SUM_W'(win_reg[2]) + (SUM_W'(win_reg[5]) << 1) + SUM_W'(win_reg[8]);
        lf_next = SUM_W'(win_reg[0]) + (SUM_W'(win_reg[3]) << 1) + SUM_W'(win_reg[6]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (beat.valid)
            begin
                last2_reg <= beat.last;
                row2_reg  <= beat.out_row;
                col2_reg  <= beat.out_col;
            end
            last3_reg <= last2_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            up_reg    <= up_next;
            dn_reg    <= dn_next;
            rt_reg    <= rt_next;
            lf_reg    <= lf_next;
        end
    end

    always_comb
    begin
        diff_y = (up_reg >= dn_reg) ? (up_reg - dn_reg) : (dn_reg - up_reg);
        diff_x = (rt_reg >= lf_reg) ? (rt_reg - lf_reg) : (lf_reg - rt_reg);
        total  = {1'b0, diff_y} + {1'b0, diff_x};
    end

    // magnitude wraps to its low byte
    always_comb
    begin
        res_valid      = v3_reg;
        res.edge_value = total[PIX_W-1:0];
        res.out_row    = row3_reg;
        res.out_col    = col3_reg;
        res.frame_last = last3_reg;
    end

endmodule
